[rtl/jsu_pkg.sv]
package jsu_pkg;

  // Result queue sizing: one byte gives at most three results.
  localparam int JSU_MAX_RES = 3;
  localparam int JSU_QDEPTH  = 4;
  localparam int JSU_NW      = $clog2(JSU_MAX_RES + 1);

  typedef logic [JSU_NW-1:0] jsu_cnt_t;
  localparam jsu_cnt_t JSU_MAX_N = jsu_cnt_t'(JSU_MAX_RES);

  // Result status codes
  localparam logic [1:0] STAT_UNIT = 2'd0;
  localparam logic [1:0] STAT_END  = 2'd1;
  localparam logic [1:0] STAT_ERR  = 2'd2;

  // Replacement unit for malformed UTF-8
  localparam logic [15:0] REPL_UNIT = 16'hFFFF;

  // Characters
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } jsu_in_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic [1:0]  status;
    logic        last_result;
  } jsu_res_t;

  // Results of one byte, written into the queue together
  typedef struct packed {
    jsu_cnt_t                    n;
    jsu_res_t [JSU_MAX_RES-1:0] res;
  } jsu_push_t;

endpackage

[rtl/jsu_chan_if.sv]
interface jsu_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/jsu_step.sv]
module jsu_step import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  jsu_in_t   item,
  output jsu_push_t push
);

  typedef enum logic [1:0] {MODE_TEXT, MODE_ESC, MODE_HEX} mode_t;

  mode_t       mode, mode_next;
  logic [2:0]  hex_count, hex_count_next;
  logic [15:0] hex_value, hex_value_next;
  logic [20:0] utf8_code, utf8_code_next;
  logic [1:0]  utf8_remaining, utf8_remaining_next;
  logic [20:0] utf8_min, utf8_min_next;
  logic        drop_until_last, drop_until_last_next;

  logic [7:0]  b;
  logic        cont, bad, is_hex, plain_go, lead_go, err;
  logic [20:0] nc, lo, hi, v;
  logic [1:0]  r;
  logic [3:0]  digit;
  jsu_cnt_t    n;
  jsu_res_t [JSU_MAX_RES-1:0] res;

  function automatic jsu_res_t mk(logic [15:0] cu, logic [1:0] st, logic lr);
    jsu_res_t x;
    x.code_unit   = cu;
    x.status      = st;
    x.last_result = lr;
    return x;
  endfunction

  always_comb begin
    b    = item.in_byte;
    cont = (b[7:6] == 2'b10);
    nc   = {utf8_code[14:0], b[5:0]};
    r    = utf8_remaining - 2'd1;
    case (r)
      2'd0: begin
        lo = nc;
        hi = nc;
      end
      2'd1: begin
        lo = {nc[14:0], 6'b0};
        hi = {nc[14:0], 6'h3F};
      end
      default: begin
        lo = {nc[8:0], 12'b0};
        hi = {nc[8:0], 12'hFFF};
      end
    endcase
    bad = (hi < utf8_min) || (lo > 21'h10FFFF) ||
          ((lo >= 21'h00D800) && (hi <= 21'h00DFFF));
    v   = nc - 21'h010000;

    is_hex = 1'b1;
    digit  = b[3:0];
    if (b inside {[8'h30:8'h39]}) begin
      digit = b[3:0];
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      digit = b[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end

    mode_next            = mode;
    hex_count_next       = hex_count;
    hex_value_next       = hex_value;
    utf8_code_next       = utf8_code;
    utf8_remaining_next  = utf8_remaining;
    utf8_min_next        = utf8_min;
    drop_until_last_next = drop_until_last;
    n        = '0;
    res      = '0;
    err      = 1'b0;
    plain_go = 1'b0;
    lead_go  = 1'b0;

    if (drop_until_last) begin
      if (item.last_byte) begin
        drop_until_last_next = 1'b0;
      end
    end else begin
      case (mode)
        MODE_ESC: begin
          mode_next = MODE_TEXT;
          case (b)
            CH_U: begin
              mode_next      = MODE_HEX;
              hex_count_next = '0;
              hex_value_next = '0;
            end
            CH_QUOTE, CH_BSLASH, CH_SLASH: begin
              res[n] = mk({8'h00, b}, STAT_UNIT, 1'b0);
              n = n + jsu_cnt_t'(1);
            end
            CH_B: begin
              res[n] = mk(16'h0008, STAT_UNIT, 1'b0);
              n = n + jsu_cnt_t'(1);
            end
            CH_N: begin
              res[n] = mk(16'h000A, STAT_UNIT, 1'b0);
              n = n + jsu_cnt_t'(1);
            end
            CH_R: begin
              res[n] = mk(16'h000D, STAT_UNIT, 1'b0);
              n = n + jsu_cnt_t'(1);
            end
            CH_T: begin
              res[n] = mk(16'h0009, STAT_UNIT, 1'b0);
              n = n + jsu_cnt_t'(1);
            end
            default: err = 1'b1;
          endcase
        end
        MODE_HEX: begin
          if (is_hex && (hex_count < 3'd4)) begin
            hex_value_next = {hex_value[11:0], digit};
            hex_count_next = hex_count + 3'd1;
            if (hex_count == 3'd3) begin
              res[n] = mk(hex_value_next, STAT_UNIT, 1'b0);
              n = n + jsu_cnt_t'(1);
              mode_next      = MODE_TEXT;
              hex_count_next = '0;
              hex_value_next = '0;
            end
          end else begin
            res[n] = mk(hex_value, STAT_UNIT, 1'b0);
            n = n + jsu_cnt_t'(1);
            mode_next      = MODE_TEXT;
            hex_count_next = '0;
            hex_value_next = '0;
            plain_go       = 1'b1;
          end
        end
        default: begin
          mode_next = MODE_TEXT;
          plain_go  = 1'b1;
        end
      endcase

      // Plain text: continue a pending sequence, else decode as a lead byte
      if (plain_go) begin
        lead_go = 1'b1;
        if (utf8_remaining != 2'd0) begin
          if (cont && !bad) begin
            lead_go             = 1'b0;
            utf8_code_next      = nc;
            utf8_remaining_next = r;
            if (r == 2'd0) begin
              if (nc[20:16] != 5'd0) begin
                res[n] = mk({6'b110110, v[19:10]}, STAT_UNIT, 1'b0);
                n = n + jsu_cnt_t'(1);
                res[n] = mk({6'b110111, v[9:0]}, STAT_UNIT, 1'b0);
                n = n + jsu_cnt_t'(1);
              end else begin
                res[n] = mk(nc[15:0], STAT_UNIT, 1'b0);
                n = n + jsu_cnt_t'(1);
              end
              utf8_code_next      = '0;
              utf8_remaining_next = '0;
              utf8_min_next       = '0;
            end
          end else begin
            res[n] = mk(REPL_UNIT, STAT_UNIT, 1'b0);
            n = n + jsu_cnt_t'(1);
            utf8_code_next      = '0;
            utf8_remaining_next = '0;
            utf8_min_next       = '0;
          end
        end
        if (lead_go) begin
          if (b == CH_BSLASH) begin
            mode_next = MODE_ESC;
          end else if (b[7] == 1'b0) begin
            res[n] = mk({8'h00, b}, STAT_UNIT, 1'b0);
            n = n + jsu_cnt_t'(1);
          end else if (b inside {[8'hC2:8'hDF]}) begin
            utf8_code_next      = {16'b0, b[4:0]};
            utf8_remaining_next = 2'd1;
            utf8_min_next       = 21'h000080;
          end else if (b inside {[8'hE0:8'hEF]}) begin
            utf8_code_next      = {17'b0, b[3:0]};
            utf8_remaining_next = 2'd2;
            utf8_min_next       = 21'h000800;
          end else if (b inside {[8'hF0:8'hF4]}) begin
            utf8_code_next      = {18'b0, b[2:0]};
            utf8_remaining_next = 2'd3;
            utf8_min_next       = 21'h010000;
          end else begin
            res[n] = mk(REPL_UNIT, STAT_UNIT, 1'b0);
            n = n + jsu_cnt_t'(1);
          end
        end
      end

      // Close out: error, or end of string
      if (err || (item.last_byte && (mode_next == MODE_ESC))) begin
        if (n != JSU_MAX_N) begin
          res[n] = mk(16'h0000, STAT_ERR, 1'b1);
          n = n + jsu_cnt_t'(1);
        end
        drop_until_last_next = err && !item.last_byte;
      end else if (item.last_byte) begin
        if (mode_next == MODE_HEX) begin
          res[n] = mk(hex_value_next, STAT_UNIT, 1'b0);
          n = n + jsu_cnt_t'(1);
        end
        if (utf8_remaining_next != 2'd0) begin
          res[n] = mk(REPL_UNIT, STAT_UNIT, 1'b0);
          n = n + jsu_cnt_t'(1);
        end
        if (n != JSU_MAX_N) begin
          res[n] = mk(16'h0000, STAT_END, 1'b1);
          n = n + jsu_cnt_t'(1);
        end
      end

      if (err || item.last_byte) begin
        mode_next           = MODE_TEXT;
        hex_count_next      = '0;
        hex_value_next      = '0;
        utf8_code_next      = '0;
        utf8_remaining_next = '0;
        utf8_min_next       = '0;
      end
    end

    push.n   = take ? n : '0;
    push.res = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_TEXT;
      hex_count       <= '0;
      hex_value       <= '0;
      utf8_code       <= '0;
      utf8_remaining  <= '0;
      utf8_min        <= '0;
      drop_until_last <= 1'b0;
    end else if (take) begin
      mode            <= mode_next;
      hex_count       <= hex_count_next;
      hex_value       <= hex_value_next;
      utf8_code       <= utf8_code_next;
      utf8_remaining  <= utf8_remaining_next;
      utf8_min        <= utf8_min_next;
      drop_until_last <= drop_until_last_next;
    end
  end

  // Dropping state always holds a cleared decoder
  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    drop_until_last |-> (mode == MODE_TEXT) && (utf8_remaining == 2'd0) &&
                        (hex_count == 3'd0))
    else $error("dropping with live decoder state");

  // No UTF-8 sequence is open across an escape
  a_hex_no_utf8: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_HEX || mode == MODE_ESC) |-> (utf8_remaining == 2'd0))
    else $error("UTF-8 sequence open during escape");

  // A last byte leaves the decoder in its reset state
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    take && item.last_byte |=> (mode == MODE_TEXT) && !drop_until_last &&
                               (utf8_remaining == 2'd0) && (hex_count == 3'd0))
    else $error("state left over after last byte");

endmodule

[rtl/jsu_queue.sv]
module jsu_queue import jsu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  jsu_push_t         push,
  output logic              room,
  jsu_chan_if.source        units
);

  localparam int PTR_W = $clog2(JSU_QDEPTH);
  localparam int CNT_W = $clog2(JSU_QDEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_LIM = CNT_W'(JSU_QDEPTH - JSU_MAX_RES);
  localparam logic [CNT_W-1:0] FULL     = CNT_W'(JSU_QDEPTH);

  jsu_res_t         mem [JSU_QDEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign tail        = head + count[PTR_W-1:0];
  assign pop         = units.valid && units.ready;
  assign room        = (count <= ROOM_LIM);
  assign units.valid = (count != '0);
  assign units.data  = mem[head];

  always_ff @(posedge clk) begin
    for (int i = 0; i < JSU_MAX_RES; i++) begin
      if (jsu_cnt_t'(i) < push.n) begin
        mem[tail + PTR_W'(i)] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + PTR_W'(1);
      end
      count <= count + CNT_W'(push.n) - CNT_W'(pop);
    end
  end

  // Writes only land when room was offered
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != '0) |-> (count <= ROOM_LIM))
    else $error("queue written without room");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (count == '0))
    else $error("queue not empty after reset");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("queue overflow");

endmodule

[rtl/json_string_unescape_utf16.sv]
// A byte's results are written into the result queue when the byte transfers.
// Throughput: one byte per cycle while units is ready and each byte gives
// at most one result; a byte that gives two or three results holds
// bytes.ready low while the result queue drains.
// Reset: synchronous rst clears the decoder state and empties the result queue.
module json_string_unescape_utf16 import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  jsu_chan_if.sink   bytes,
  jsu_chan_if.source units
);

  // Data path:
  //   bytes -> jsu_step (decoder state + single-pass decode of one byte)
  //         -> jsu_queue (4-entry result queue) -> units
  // The decoder's combinational step produces every result of a byte at
  // once (up to three code units or end/error marks) and the queue takes
  // them in the same clock edge that accepts the byte. The queue then
  // hands out one result per transfer.

  jsu_push_t push;
  logic      room;
  logic      take;

  // A byte is taken only when the queue can hold a worst-case byte's
  // three results, so nothing is ever dropped.
  assign bytes.ready = room;
  assign take        = bytes.valid && bytes.ready;

  jsu_step u_step (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (bytes.data),
    .push (push)
  );

  // With the sink always ready and each byte giving at most one result, the
  // queue holds at most one result between bytes, so bytes stream without stalls.
  jsu_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .units (units)
  );

endmodule
